[sv/cpfm_pkg.sv]
// cpfm_pkg: shared widths, constants and handshake structs of the capture pair frequency meter
// no dependencies; used by cpfm_div and capture_pair_frequency_meter
package cpfm_pkg;

  // fixed field widths
  localparam int CAPTURE_W  = 16;
  localparam int CLOCK_W    = 27;
  localparam int PERIOD_W   = 16;
  localparam int FREQ_W     = 35;

  // bus packing
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 56;
  localparam int OUT_TUSER_W = 1;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // register index, taken from the word address bit
  localparam logic REG_CLOCK_HZ = 1'b0;

  // reset and limits
  localparam logic [CLOCK_W-1:0] CLOCK_RESET = 27'd10500000;
  localparam logic [FREQ_W-1:0]  FREQ_MAX    = 35'h7_FFFF_FFFF;

  // parameter defaults
  localparam int COUNTER_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF    = 8;

  // divider control and status
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[sv/capture_pair_frequency_meter.sv]
// capture_pair_frequency_meter: pairs counter captures and reports period and frequency
// depends on cpfm_pkg and cpfm_div
//
// Capture values arrive one item at a time on in_*; the first of a pair is stored and
// gives no result, the second gives one result item on out_* carrying the period
// (second minus first, modulo 2^COUNTER_BITS) and clock_hz / period with FRAC_BITS
// fraction bits, truncated and saturated to 35 bits. Equal captures set zero_period
// and report a frequency of 0. A first capture is stored with in_tready left high. A
// second capture holds in_tready low while the sequencer starts the restoring
// divider, waits for its quotient bits, sees it finish and loads the result register,
// plus a wait if the previous result is still held on out_*. Equal captures skip the
// divider and load the result register after that wait alone. in_tready is low while
// a pair is being worked on. clock_hz sits at byte address 0 of the APB port and
// resets to 10500000.
module capture_pair_frequency_meter #(
  parameter int COUNTER_BITS = cpfm_pkg::COUNTER_BITS_DEF,
  parameter int FRAC_BITS    = cpfm_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // capture input
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [cpfm_pkg::IN_TDATA_W-1:0]  in_tdata,   // [15:0] capture_value
  // result output
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [cpfm_pkg::OUT_TDATA_W-1:0] out_tdata,  // [15:0] period_ticks,
                                                       // [50:16] frequency_q8, rest zero
  output logic [cpfm_pkg::OUT_TUSER_W-1:0] out_tuser,  // [0] zero_period
  // configuration
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [cpfm_pkg::CFG_ADDR_W-1:0]  cfg_paddr,
  input  logic [cpfm_pkg::CFG_DATA_W-1:0]  cfg_pwdata,
  output logic [cpfm_pkg::CFG_DATA_W-1:0]  cfg_prdata,
  output logic                            cfg_pready
);
  import cpfm_pkg::*;

  localparam int DVD_W = CLOCK_W + FRAC_BITS;
  localparam int EXT_W = (DVD_W > FREQ_W) ? DVD_W : FREQ_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_PUSH = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic                    pending_r, pending_nxt;
  logic [CAPTURE_W-1:0]    first_r, first_nxt;
  logic [COUNTER_BITS-1:0] period_r, period_nxt;
  logic                    zero_r, zero_nxt;
  logic [CLOCK_W-1:0]      clock_r, clock_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic [PERIOD_W-1:0]     out_period_r, out_period_nxt;
  logic [FREQ_W-1:0]       out_freq_r, out_freq_nxt;
  logic                    out_zero_r, out_zero_nxt;

  div_ctrl_t               div_ctrl;
  div_stat_t               div_stat;
  logic [DVD_W-1:0]        quotient;
  logic [EXT_W-1:0]        quo_ext;
  logic [FREQ_W-1:0]       freq_sat;

  logic                    in_fire;
  logic                    cfg_wr;
  logic                    out_free;
  logic [CAPTURE_W-1:0]    capture;
  logic [COUNTER_BITS-1:0] period_new;

  assign capture    = in_tdata[CAPTURE_W-1:0];
  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign period_new = COUNTER_BITS'(capture) - COUNTER_BITS'(first_r);

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_CLOCK_HZ) ? CFG_DATA_W'(clock_r) : '0;

  always_comb begin
    clock_nxt = clock_r;
    if (cfg_wr && cfg_paddr[2] == REG_CLOCK_HZ) begin
      clock_nxt = cfg_pwdata[CLOCK_W-1:0];
    end
  end

  // divider
  cpfm_div #(
    .DVD_W (DVD_W),
    .DSR_W (COUNTER_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (div_ctrl),
    .dividend (DVD_W'(clock_r) << FRAC_BITS),
    .divisor  (period_r),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // saturate the quotient to the output width
  always_comb begin
    quo_ext = EXT_W'(quotient);
    if (quo_ext > EXT_W'(FREQ_MAX)) begin
      freq_sat = FREQ_MAX;
    end else begin
      freq_sat = quo_ext[FREQ_W-1:0];
    end
  end

  // pairing sequencer
  always_comb begin
    state_nxt      = state_r;
    pending_nxt    = pending_r;
    first_nxt      = first_r;
    period_nxt     = period_r;
    zero_nxt       = zero_r;
    div_ctrl.start = 1'b0;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_period_nxt = out_period_r;
    out_freq_nxt   = out_freq_r;
    out_zero_nxt   = out_zero_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (!pending_r) begin
            first_nxt   = capture;
            pending_nxt = 1'b1;
          end else begin
            pending_nxt = 1'b0;
            period_nxt  = period_new;
            zero_nxt    = (period_new == '0);
            state_nxt   = (period_new == '0) ? S_PUSH : S_DIV;
          end
        end
      end
      S_DIV: begin
        div_ctrl.start = !div_stat.busy && !div_stat.done;
        if (div_stat.done) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_period_nxt = PERIOD_W'(period_r);
          out_freq_nxt   = zero_r ? '0 : freq_sat;
          out_zero_nxt   = zero_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pending_r   <= 1'b0;
      first_r     <= '0;
      clock_r     <= CLOCK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pending_r   <= pending_nxt;
      first_r     <= first_nxt;
      clock_r     <= clock_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    period_r     <= period_nxt;
    zero_r       <= zero_nxt;
    out_period_r <= out_period_nxt;
    out_freq_r   <= out_freq_nxt;
    out_zero_r   <= out_zero_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_freq_r, out_period_r});
  assign out_tuser  = out_zero_r;

`ifndef SYNTHESIS
  // divider finishes only while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> state_r == S_DIV)
    else $error("divider done outside division");

  // no new item while the divider runs
  a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.busy |-> !in_tready)
    else $error("input ready during division");

  // a nonzero pair always goes to the divider
  a_pair_divides: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && pending_r && period_new != '0 |=> state_r == S_DIV)
    else $error("nonzero period skipped division");

  // zero period result carries no period and no frequency
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("zero period result with nonzero data");
`endif

endmodule

[sv/cpfm_div.sv]
// cpfm_div: restoring bit-serial unsigned divider, one quotient bit per cycle
// depends on cpfm_pkg for the control and status structs
module cpfm_div #(
  parameter int DVD_W = 35,
  parameter int DSR_W = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cpfm_pkg::div_ctrl_t  ctrl,
  input  logic [DVD_W-1:0]     dividend,
  input  logic [DSR_W-1:0]     divisor,
  output cpfm_pkg::div_stat_t  stat,
  output logic [DVD_W-1:0]     quotient
);
  import cpfm_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DSR_W-1:0] rem_r, rem_nxt;
  logic [DSR_W-1:0] dsr_r, dsr_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;

  logic [DSR_W:0]   shl;
  logic [DSR_W:0]   diff;
  logic             ge;

  // trial subtract of the shifted partial remainder
  assign shl  = {rem_r, quo_r[DVD_W-1]};
  assign ge   = (shl >= {1'b0, dsr_r});
  assign diff = shl - {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    quo_nxt  = quo_r;
    if (ctrl.start && !busy_r) begin
      // load operands, dividend shifts out of the quotient register
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
      rem_nxt  = '0;
      dsr_nxt  = divisor;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DSR_W-1:0] : shl[DSR_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

[sim/tb_capture_pair_frequency_meter.sv]
// tb_capture_pair_frequency_meter: self-checking testbench of the capture pair frequency meter
// depends on cpfm_pkg and capture_pair_frequency_meter; predicts each period and frequency
// itself, drives random gaps and back-pressure, and programs clock_hz over the apb port
module tb_capture_pair_frequency_meter;
  timeunit 1ns;
  timeprecision 1ps;

  import cpfm_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int REPORT_MAX   = 10;
  localparam logic [CFG_ADDR_W-1:0] CLOCK_ADDR = {REG_CLOCK_HZ, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = {~REG_CLOCK_HZ, 2'b00};

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [FREQ_W-1:0]   freq;
    logic                zero;
  } meter_reading_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CFG_ADDR_W-1:0]  cfg_paddr;
  logic [CFG_DATA_W-1:0]  cfg_pwdata;
  logic [CFG_DATA_W-1:0]  cfg_prdata;
  logic                   cfg_pready;

  // predictor state
  logic                 pair_open;
  logic [CAPTURE_W-1:0] held_capture;
  logic [CLOCK_W-1:0]   meter_clock;
  meter_reading_t       pending_readings[$];
  meter_reading_t       oldest_reading;

  // run control and bookkeeping
  bit tx_gaps_on;
  bit rx_stalls_on;
  int hold_len;
  int mismatch_count;
  int readings_checked;
  int captures_sent;
  int clock_writes;
  int cycle_count;

  capture_pair_frequency_meter DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // expected reading for a pair of captures
  function automatic meter_reading_t predict_reading(input logic [CAPTURE_W-1:0] first_cap,
                                                     input logic [CAPTURE_W-1:0] second_cap,
                                                     input logic [CLOCK_W-1:0] hz);
    meter_reading_t r;
    logic [COUNTER_BITS_DEF-1:0] span;
    logic [63:0] quot;
    r = '0;
    span = second_cap - first_cap;
    if (span == 0) begin
      r.zero = 1'b1;
    end else begin
      quot = (64'(hz) << FRAC_BITS_DEF) / 64'(span);
      if (quot > 64'(FREQ_MAX)) quot = 64'(FREQ_MAX);
      r.period = PERIOD_W'(span);
      r.freq   = quot[FREQ_W-1:0];
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] want, input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX)
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  // send one capture item, with a random gap ahead of it
  task automatic send_capture(input logic [CAPTURE_W-1:0] value);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = value;
    do @(posedge clk); while (!in_tready);
    captures_sent++;
    if (!pair_open) begin
      held_capture = value;
      pair_open    = 1'b1;
    end else begin
      pair_open = 1'b0;
      pending_readings.push_back(predict_reading(held_capture, value, meter_clock));
    end
  endtask

  task automatic send_pair(input logic [CAPTURE_W-1:0] first_cap,
                           input logic [CAPTURE_W-1:0] second_cap);
    send_capture(first_cap);
    send_capture(second_cap);
  endtask

  // pair with a period drawn from a few shapes: equal, tiny, near full scale, wrapping, any
  task automatic send_random_pair();
    logic [CAPTURE_W-1:0] first_cap;
    logic [CAPTURE_W-1:0] span;
    int shape;
    first_cap = CAPTURE_W'($urandom);
    shape = $urandom_range(0, 9);
    case (shape)
      0: span = '0;
      1: span = CAPTURE_W'($urandom_range(1, 15));
      2: span = CAPTURE_W'($urandom_range(65520, 65535));
      3: begin
        first_cap = CAPTURE_W'($urandom_range(65280, 65535));
        span      = CAPTURE_W'($urandom_range(256, 4096));
      end
      default: span = CAPTURE_W'($urandom);
    endcase
    send_pair(first_cap, first_cap + span);
  endtask

  // stop sending and let every pending reading come out
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // write one address through the apb port, then read clock_hz back
  task automatic set_clock(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    wait_idle();
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = addr;
    cfg_pwdata  = data;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr[2] == REG_CLOCK_HZ) meter_clock = data[CLOCK_W-1:0];
    clock_writes++;
    // read-back cycle
    @(negedge clk);
    cfg_pwrite  = 1'b0;
    cfg_paddr   = CLOCK_ADDR;
    cfg_penable = 1'b0;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CFG_DATA_W'(meter_clock))
      flag_mismatch("clock_hz readback", 64'(meter_clock), 64'(cfg_prdata));
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // reset value of clock_hz, equal captures, smallest period, wrap, alternating bits
  task automatic test_reset_clock_pairs();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    send_pair(16'h0000, 16'h0000);
    send_pair(16'h0000, 16'h0001);
    send_pair(16'hFFFF, 16'h0000);
    send_pair(16'hAAAA, 16'h5555);
    send_pair(16'h5555, 16'hAAAA);
    wait_idle();
  endtask

  // clock_hz at its extremes, zero, masked upper bits and a write to an unused address
  task automatic test_clock_extremes();
    logic [CFG_DATA_W-1:0] settings[4];
    settings = '{32'd1, 32'd100000000, 32'hFFFF_FFFF, 32'd0};
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    foreach (settings[i]) begin
      set_clock(CLOCK_ADDR, settings[i]);
      send_pair(16'h1234, 16'h1235);
      send_pair(16'h0001, 16'h0000);
    end
    set_clock(SPARE_ADDR, 32'h0123_4567);
    set_clock(CLOCK_ADDR, 32'hA000_0000 | 32'(CLOCK_RESET));
  endtask

  // receiver holds off while the sender keeps pushing, then the sender pauses
  task automatic test_backpressure();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    hold_len     = HOLD_CYCLES;
    repeat (24) send_random_pair();
    wait_idle();
  endtask

  // random captures over several clock settings and idling mixes
  task automatic test_random_captures();
    logic [CFG_DATA_W-1:0] hz;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        1: hz = 32'd1;
        2: hz = 32'd100000000;
        5: hz = $urandom;
        default: hz = $urandom_range(1, 100000000);
      endcase
      set_clock(CLOCK_ADDR, hz);
      tx_gaps_on   = (phase == 0) ? 1'b0 : 1'($urandom);
      rx_stalls_on = (phase == 0) ? 1'b0 : 1'($urandom);
      repeat (70) begin
        // an odd lone capture now and then shifts the pairing
        if ($urandom_range(0, 19) == 0) send_capture(CAPTURE_W'($urandom));
        else send_random_pair();
      end
    end
    wait_idle();
  endtask

  // stimulus and final verdict
  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    pair_open    = 1'b0;
    held_capture = '0;
    meter_clock  = CLOCK_RESET;
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    hold_len     = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    test_reset_clock_pairs();
    test_clock_extremes();
    test_backpressure();
    test_random_captures();
    wait_idle();

    if (pending_readings.size() != 0)
      flag_mismatch("readings left over", 0, 64'(pending_readings.size()));
    $display("sent %0d captures, checked %0d readings across %0d clock_hz writes",
             captures_sent, readings_checked, clock_writes);
    $display("covered equal captures, counter wrap, clock extremes and output back-pressure");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // receiver: random stalls per item, plus a long hold-off on request
  initial begin
    int stall;
    out_tready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_tready = 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end
      stall = rx_stalls_on ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid && hold_len == 0);
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        flag_mismatch("result with nothing pending", 0, 64'(out_tdata));
      end else begin
        oldest_reading = pending_readings.pop_front();
        readings_checked++;
        if (out_tdata[15:0] !== oldest_reading.period)
          flag_mismatch("period_ticks", 64'(oldest_reading.period), 64'(out_tdata[15:0]));
        if (out_tdata[50:16] !== oldest_reading.freq)
          flag_mismatch("frequency_q8", 64'(oldest_reading.freq), 64'(out_tdata[50:16]));
        if (out_tuser[0] !== oldest_reading.zero)
          flag_mismatch("zero_period", 64'(oldest_reading.zero), 64'(out_tuser[0]));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

endmodule
